// ===== design/ita_pkg.sv =====
// ita_pkg: shared types and constants for the inertia tensor accumulator
// holds beat structs, field widths and register indexes
// no dependencies

package ita_pkg;

	localparam int PosW   = 20;
	localparam int DW     = PosW + 1;
	localparam int MassW  = 16;
	localparam int MdW    = 38;
	localparam int ProdW  = MdW + DW;
	localparam int SumW   = 64;
	localparam int NumSum = 6;

	localparam int CfgAddrW = 3;
	localparam int CfgDataW = PosW;

	localparam logic [CfgAddrW-1:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [CfgAddrW-1:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [CfgAddrW-1:0] CFG_ORIGIN_Z   = 3'd2;
	localparam logic [CfgAddrW-1:0] CFG_USE_INSIDE = 3'd3;
	localparam logic [CfgAddrW-1:0] CFG_USE_SHELL  = 3'd4;

	typedef struct packed {
		logic signed [PosW-1:0]  pos_x;
		logic signed [PosW-1:0]  pos_y;
		logic signed [PosW-1:0]  pos_z;
		logic        [MassW-1:0] mass;
		logic                    inside_flag;
		logic                    shell_flag;
		logic                    last;
	} pt_beat_t;

	typedef struct packed {
		logic signed [SumW-1:0] ixx;
		logic signed [SumW-1:0] iyy;
		logic signed [SumW-1:0] izz;
		logic signed [SumW-1:0] ixy;
		logic signed [SumW-1:0] ixz;
		logic signed [SumW-1:0] iyz;
	} res_beat_t;

	typedef struct packed {
		logic add;
		logic clear;
	} acc_ctrl_t;

endpackage

// ===== design/ita_mul.sv =====
// ita_mul: shared signed multiplier for all nine products of one particle
// depends on ita_pkg for operand and product widths

module ita_mul (
	input  logic signed [ita_pkg::MdW-1:0]   a,
	input  logic signed [ita_pkg::DW-1:0]    b,
	output logic signed [ita_pkg::ProdW-1:0] p
);

	logic signed [ita_pkg::ProdW-1:0] a_ext;
	logic signed [ita_pkg::ProdW-1:0] b_ext;

	assign a_ext = ita_pkg::ProdW'(a);
	assign b_ext = ita_pkg::ProdW'(b);
	assign p     = a_ext * b_ext;

endmodule

// ===== design/ita_accum.sv =====
// ita_accum: bank of six saturating 64-bit tensor sums
// depends on ita_pkg for widths and the control struct

module ita_accum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ita_pkg::acc_ctrl_t               ctrl,
	input  logic signed [ita_pkg::SumW-1:0]  contrib [ita_pkg::NumSum],
	output logic signed [ita_pkg::SumW-1:0]  sums    [ita_pkg::NumSum]
);

	logic signed [ita_pkg::SumW-1:0] sum_q [ita_pkg::NumSum];

	function automatic logic signed [ita_pkg::SumW-1:0] sat_add(
		input logic signed [ita_pkg::SumW-1:0] x,
		input logic signed [ita_pkg::SumW-1:0] y
	);
		logic signed [ita_pkg::SumW:0]   s;
		logic signed [ita_pkg::SumW-1:0] r;
		s = {x[ita_pkg::SumW-1], x} + {y[ita_pkg::SumW-1], y};
		if (s[ita_pkg::SumW] != s[ita_pkg::SumW-1]) begin
			r = s[ita_pkg::SumW] ? {1'b1, {(ita_pkg::SumW-1){1'b0}}}
			                     : {1'b0, {(ita_pkg::SumW-1){1'b1}}};
		end else begin
			r = s[ita_pkg::SumW-1:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ita_pkg::NumSum; k++) sum_q[k] <= '0;
		end else if (ctrl.clear) begin
			for (int k = 0; k < ita_pkg::NumSum; k++) sum_q[k] <= '0;
		end else if (ctrl.add) begin
			for (int k = 0; k < ita_pkg::NumSum; k++) sum_q[k] <= sat_add(sum_q[k], contrib[k]);
		end
	end

	assign sums = sum_q;

endmodule

// ===== design/inertia_tensor_accumulator.sv =====
// inertia_tensor_accumulator: top level with sequencer, operand select and result register
// depends on ita_pkg, ita_mul and ita_accum
//
// usage: particles arrive as pt beats (pt_valid/pt_ready); a particle is taken
// when both are high. positions are made relative to the origin registers, and
// the particle adds into the six tensor sums once per enabled matching set.
// a beat with last set pushes the six sums out on the res channel
// (res_valid/res_ready) and clears the sums for the next set.
// the particle rate is set by nine passes through the single shared multiplier,
// two accumulate steps and the idle state in which the beat is taken; a last
// particle also goes through the result step, which can stall on the res channel.
// after the last particle's accept, res_valid rises from the result register once that result step completes.
// the result sits in an output register, so the next particle is taken while
// a result still waits; a second result stalls in its final step until the
// receiver takes the first beat.
// configuration writes (cfg_we, cfg_addr, cfg_data) take effect at once and
// belong only in idle periods; unknown addresses are ignored.
// reset clears the sums, sets the origin to zero, enables the inside set and
// disables the shell set.

module inertia_tensor_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pt_valid,
	output logic                           pt_ready,
	input  ita_pkg::pt_beat_t              pt,
	output logic                           res_valid,
	input  logic                           res_ready,
	output ita_pkg::res_beat_t             res,
	input  logic                           cfg_we,
	input  logic [ita_pkg::CfgAddrW-1:0]   cfg_addr,
	input  logic [ita_pkg::CfgDataW-1:0]   cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD1 = 3'd2;
	localparam logic [2:0] ST_ADD2 = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [3:0] STEP_MX  = 4'd0;
	localparam logic [3:0] STEP_MY  = 4'd1;
	localparam logic [3:0] STEP_MZ  = 4'd2;
	localparam logic [3:0] STEP_XX  = 4'd3;
	localparam logic [3:0] STEP_YY  = 4'd4;
	localparam logic [3:0] STEP_ZZ  = 4'd5;
	localparam logic [3:0] STEP_XY  = 4'd6;
	localparam logic [3:0] STEP_XZ  = 4'd7;
	localparam logic [3:0] STEP_YZ  = 4'd8;

	localparam int PX = 0;
	localparam int PY = 1;
	localparam int PZ = 2;
	localparam int PXY = 3;
	localparam int PXZ = 4;
	localparam int PYZ = 5;

	logic [2:0] state_q;
	logic [3:0] step_q;

	logic signed [ita_pkg::PosW-1:0] origin_q [3];
	logic                            use_inside_q;
	logic                            use_shell_q;

	logic signed [ita_pkg::DW-1:0]    d_q   [3];
	logic        [ita_pkg::MassW-1:0] mass_q;
	logic                             inside_q;
	logic                             shell_q;
	logic                             last_q;
	logic signed [ita_pkg::MdW-1:0]   md_q  [3];
	logic signed [ita_pkg::ProdW-1:0] prod_q [ita_pkg::NumSum];

	logic signed [ita_pkg::MdW-1:0]   mul_a;
	logic signed [ita_pkg::DW-1:0]    mul_b;
	logic signed [ita_pkg::ProdW-1:0] mul_p;

	ita_pkg::acc_ctrl_t              acc_ctrl;
	logic signed [ita_pkg::SumW-1:0] contrib [ita_pkg::NumSum];
	logic signed [ita_pkg::SumW-1:0] acc_sum [ita_pkg::NumSum];

	ita_pkg::res_beat_t res_q;
	logic               res_valid_q;
	logic               fin_go;

	function automatic logic signed [ita_pkg::SumW-1:0] sx(
		input logic signed [ita_pkg::ProdW-1:0] v
	);
		return {{(ita_pkg::SumW-ita_pkg::ProdW){v[ita_pkg::ProdW-1]}}, v};
	endfunction

	assign pt_ready = (state_q == ST_IDLE);
	assign fin_go   = (state_q == ST_FIN) && (!res_valid_q || res_ready);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0]  <= '0;
			origin_q[1]  <= '0;
			origin_q[2]  <= '0;
			use_inside_q <= 1'b1;
			use_shell_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				ita_pkg::CFG_ORIGIN_X:   origin_q[0]  <= cfg_data;
				ita_pkg::CFG_ORIGIN_Y:   origin_q[1]  <= cfg_data;
				ita_pkg::CFG_ORIGIN_Z:   origin_q[2]  <= cfg_data;
				ita_pkg::CFG_USE_INSIDE: use_inside_q <= cfg_data[0];
				ita_pkg::CFG_USE_SHELL:  use_shell_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = ita_pkg::MdW'($signed({1'b0, mass_q}));
		mul_b = d_q[0];
		case (step_q)
			STEP_MX: begin mul_a = ita_pkg::MdW'($signed({1'b0, mass_q})); mul_b = d_q[0]; end
			STEP_MY: begin mul_a = ita_pkg::MdW'($signed({1'b0, mass_q})); mul_b = d_q[1]; end
			STEP_MZ: begin mul_a = ita_pkg::MdW'($signed({1'b0, mass_q})); mul_b = d_q[2]; end
			STEP_XX: begin mul_a = md_q[0]; mul_b = d_q[0]; end
			STEP_YY: begin mul_a = md_q[1]; mul_b = d_q[1]; end
			STEP_ZZ: begin mul_a = md_q[2]; mul_b = d_q[2]; end
			STEP_XY: begin mul_a = md_q[0]; mul_b = d_q[1]; end
			STEP_XZ: begin mul_a = md_q[0]; mul_b = d_q[2]; end
			STEP_YZ: begin mul_a = md_q[1]; mul_b = d_q[2]; end
			default: ;
		endcase
	end

	ita_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pt_valid) begin
						state_q <= ST_MUL;
						step_q  <= STEP_MX;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_YZ) begin
						state_q <= ST_ADD1;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_FIN: begin
					if (fin_go) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// particle capture and product registers
	always_ff @(posedge clk) begin
		if (pt_valid && pt_ready) begin
			d_q[0]   <= $signed({pt.pos_x[ita_pkg::PosW-1], pt.pos_x})
			          - $signed({origin_q[0][ita_pkg::PosW-1], origin_q[0]});
			d_q[1]   <= $signed({pt.pos_y[ita_pkg::PosW-1], pt.pos_y})
			          - $signed({origin_q[1][ita_pkg::PosW-1], origin_q[1]});
			d_q[2]   <= $signed({pt.pos_z[ita_pkg::PosW-1], pt.pos_z})
			          - $signed({origin_q[2][ita_pkg::PosW-1], origin_q[2]});
			mass_q   <= pt.mass;
			inside_q <= pt.inside_flag;
			shell_q  <= pt.shell_flag;
			last_q   <= pt.last;
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				STEP_MX: md_q[0]     <= mul_p[ita_pkg::MdW-1:0];
				STEP_MY: md_q[1]     <= mul_p[ita_pkg::MdW-1:0];
				STEP_MZ: md_q[2]     <= mul_p[ita_pkg::MdW-1:0];
				STEP_XX: prod_q[PX]  <= mul_p;
				STEP_YY: prod_q[PY]  <= mul_p;
				STEP_ZZ: prod_q[PZ]  <= mul_p;
				STEP_XY: prod_q[PXY] <= mul_p;
				STEP_XZ: prod_q[PXZ] <= mul_p;
				STEP_YZ: prod_q[PYZ] <= mul_p;
				default: ;
			endcase
		end
	end

	// per-particle contributions
	always_comb begin
		contrib[0] = sx(prod_q[PY]) + sx(prod_q[PZ]);
		contrib[1] = sx(prod_q[PX]) + sx(prod_q[PZ]);
		contrib[2] = sx(prod_q[PX]) + sx(prod_q[PY]);
		contrib[3] = -sx(prod_q[PXY]);
		contrib[4] = -sx(prod_q[PXZ]);
		contrib[5] = -sx(prod_q[PYZ]);
	end

	always_comb begin
		acc_ctrl.add   = ((state_q == ST_ADD1) && use_inside_q && inside_q)
		              || ((state_q == ST_ADD2) && use_shell_q && shell_q);
		acc_ctrl.clear = fin_go;
	end

	ita_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (acc_ctrl),
		.contrib (contrib),
		.sums    (acc_sum)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			res_q.ixx <= acc_sum[0];
			res_q.iyy <= acc_sum[1];
			res_q.izz <= acc_sum[2];
			res_q.ixy <= acc_sum[3];
			res_q.ixz <= acc_sum[4];
			res_q.iyz <= acc_sum[5];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && pt_ready |=> !pt_ready)
		else $error("particle accepted while sequencer busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> step_q <= STEP_YZ)
		else $error("multiply step out of range");

	a_add_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_ctrl.add && acc_ctrl.clear))
		else $error("sums added and cleared together");

	a_clear_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctrl.clear |=> res_valid_q)
		else $error("sums cleared without a result beat");

	a_fin_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD2 && !last_q |=> state_q == ST_IDLE)
		else $error("result step entered for a non-last particle");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for inertia_tensor_accumulator: table, saturation, random sets
// a local predictor forms the six saturated tensor sums per set; every result beat is compared
// depends on ita_pkg and the inertia_tensor_accumulator rtl

module tb_top;

	localparam int P_MAX = 524287;
	localparam int P_MIN = -524288;
	localparam int M_MAX = 65535;
	localparam int SETTLE = 20;
	localparam int IDLE_LIMIT = 2000;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 85;
	localparam int SAT_RUN = 262;
	localparam logic [ita_pkg::CfgAddrW-1:0] CFG_SPARE_A = 3'd5;
	localparam logic [ita_pkg::CfgAddrW-1:0] CFG_SPARE_B = 3'd6;
	localparam logic [ita_pkg::CfgAddrW-1:0] CFG_SPARE_C = 3'd7;
	localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		ita_pkg::pt_beat_t  b;
		bit                 typed;
		ita_pkg::res_beat_t t;
	} row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         pt_valid;
	logic                         pt_ready;
	ita_pkg::pt_beat_t            pt;
	logic                         res_valid;
	logic                         res_ready;
	ita_pkg::res_beat_t           res;
	logic                         cfg_we;
	logic [ita_pkg::CfgAddrW-1:0] cfg_addr;
	logic [ita_pkg::CfgDataW-1:0] cfg_data;

	logic signed [ita_pkg::PosW-1:0] org_x, org_y, org_z;
	bit                              inside_en, shell_en;
	longint                          diag_acc [3];
	longint                          off_acc [3];

	ita_pkg::res_beat_t tensor_q [$];
	row_t               rows [$];
	int                 both_from;
	bit                 quiet;
	int                 errors, particles, tensors, idle_cycles;

	inertia_tensor_accumulator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_ready  (pt_ready),
		.pt        (pt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat_add64(input longint a, input longint b);
		logic signed [ita_pkg::SumW:0] s;
		s = {a[ita_pkg::SumW-1], a} + {b[ita_pkg::SumW-1], b};
		if (s[ita_pkg::SumW] != s[ita_pkg::SumW-1]) return s[ita_pkg::SumW] ? SUM_MIN : SUM_MAX;
		return s[ita_pkg::SumW-1:0];
	endfunction

	function automatic void reset_model();
		org_x = '0;
		org_y = '0;
		org_z = '0;
		inside_en = 1'b1;
		shell_en = 1'b0;
		for (int k = 0; k < 3; k++) begin
			diag_acc[k] = 0;
			off_acc[k] = 0;
		end
	endfunction

	function automatic void apply_reg(input logic [ita_pkg::CfgAddrW-1:0] a,
			input logic [ita_pkg::CfgDataW-1:0] d);
		case (a)
			ita_pkg::CFG_ORIGIN_X:   org_x = d;
			ita_pkg::CFG_ORIGIN_Y:   org_y = d;
			ita_pkg::CFG_ORIGIN_Z:   org_z = d;
			ita_pkg::CFG_USE_INSIDE: inside_en = d[0];
			ita_pkg::CFG_USE_SHELL:  shell_en = d[0];
			default: ;
		endcase
	endfunction

	function automatic bit absorb_particle(input ita_pkg::pt_beat_t b,
			output ita_pkg::res_beat_t t);
		longint dx, dy, dz, m;
		longint dg [3];
		longint od [3];
		int     n;
		dx = longint'($signed(b.pos_x)) - longint'(org_x);
		dy = longint'($signed(b.pos_y)) - longint'(org_y);
		dz = longint'($signed(b.pos_z)) - longint'(org_z);
		m = longint'(b.mass);
		dg[0] = m * (dy * dy + dz * dz);
		dg[1] = m * (dx * dx + dz * dz);
		dg[2] = m * (dx * dx + dy * dy);
		od[0] = -((m * dx) * dy);
		od[1] = -((m * dx) * dz);
		od[2] = -((m * dy) * dz);
		// a particle in both enabled sets adds twice, each add saturating on its own
		n = int'(inside_en && b.inside_flag) + int'(shell_en && b.shell_flag);
		for (int p = 0; p < n; p++) begin
			for (int k = 0; k < 3; k++) begin
				diag_acc[k] = sat_add64(diag_acc[k], dg[k]);
				off_acc[k] = sat_add64(off_acc[k], od[k]);
			end
		end
		t = '0;
		if (!b.last) return 1'b0;
		t.ixx = diag_acc[0];
		t.iyy = diag_acc[1];
		t.izz = diag_acc[2];
		t.ixy = off_acc[0];
		t.ixz = off_acc[1];
		t.iyz = off_acc[2];
		for (int k = 0; k < 3; k++) begin
			diag_acc[k] = 0;
			off_acc[k] = 0;
		end
		return 1'b1;
	endfunction

	function automatic ita_pkg::pt_beat_t mk_pt(input logic [ita_pkg::PosW-1:0] x,
			input logic [ita_pkg::PosW-1:0] y, input logic [ita_pkg::PosW-1:0] z,
			input logic [ita_pkg::MassW-1:0] m, input bit in_f, input bit sh_f,
			input bit lst);
		ita_pkg::pt_beat_t b;
		b.pos_x = x;
		b.pos_y = y;
		b.pos_z = z;
		b.mass = m;
		b.inside_flag = in_f;
		b.shell_flag = sh_f;
		b.last = lst;
		return b;
	endfunction

	function automatic ita_pkg::res_beat_t ten(input longint xx, input longint yy,
			input longint zz, input longint xy, input longint xz, input longint yz);
		ita_pkg::res_beat_t t;
		t.ixx = xx;
		t.iyy = yy;
		t.izz = zz;
		t.ixy = xy;
		t.ixz = xz;
		t.iyz = yz;
		return t;
	endfunction

	function automatic void add_row(input ita_pkg::pt_beat_t b, input bit typed,
			input ita_pkg::res_beat_t t);
		row_t r;
		r.b = b;
		r.typed = typed;
		r.t = t;
		rows.push_back(r);
	endfunction

	function automatic void load_rows();
		longint                         dmax, omax;
		logic [ita_pkg::PosW-1:0]       pmax, pmin;
		logic [ita_pkg::MassW-1:0]      mmax;
		dmax = longint'(M_MAX) << 39;
		omax = -(longint'(M_MAX) << 38);
		pmax = ita_pkg::PosW'(P_MAX);
		pmin = ita_pkg::PosW'(P_MIN);
		mmax = ita_pkg::MassW'(M_MAX);
		// reset settings: inside set on, shell set off, origin at zero
		add_row(mk_pt(3, 0, 0, 1, 1, 0, 1), 1, ten(0, 9, 9, 0, 0, 0));
		add_row(mk_pt(0, 0, 0, mmax, 1, 0, 1), 1, ten(0, 0, 0, 0, 0, 0));
		add_row(mk_pt(5, 6, 7, 100, 0, 1, 1), 1, ten(0, 0, 0, 0, 0, 0));
		add_row(mk_pt(0, 0, 4, 3, 0, 0, 0), 0, '0);
		add_row(mk_pt(1, 1, 1, 1, 0, 0, 1), 1, ten(0, 0, 0, 0, 0, 0));
		add_row(mk_pt(pmin, pmin, pmin, mmax, 1, 0, 1), 1,
			ten(dmax, dmax, dmax, omax, omax, omax));
		add_row(mk_pt(pmax, pmax, pmax, mmax, 1, 0, 1), 0, '0);
		add_row(mk_pt(pmax, pmin, 0, mmax, 1, 0, 0), 0, '0);
		add_row(mk_pt(-1, 1, -1, 1, 1, 1, 0), 0, '0);
		add_row(mk_pt(123, -456, 789, 16'h8000, 1, 0, 1), 0, '0);
		add_row(mk_pt(2, -3, 4, 5, 1, 0, 1), 1, ten(125, 100, 65, 30, -40, 60));
		add_row(mk_pt(20'h55555, 20'hAAAAA, 20'h55555, 16'h5555, 1, 1, 0), 0, '0);
		add_row(mk_pt(20'hAAAAA, 20'h55555, 20'hAAAAA, 16'hAAAA, 1, 0, 1), 0, '0);
		// shell set switched on from here
		both_from = rows.size();
		add_row(mk_pt(2, 0, 0, 1, 1, 1, 1), 1, ten(0, 8, 8, 0, 0, 0));
		add_row(mk_pt(0, 3, 0, 2, 0, 1, 1), 1, ten(18, 0, 18, 0, 0, 0));
		add_row(mk_pt(-2, 0, 1, 1, 1, 1, 0), 0, '0);
		add_row(mk_pt(pmin, pmax, pmin, mmax, 0, 1, 0), 0, '0);
		add_row(mk_pt(1, 1, 1, 0, 1, 1, 1), 0, '0);
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ita_pkg::PosW-1:0] pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return ita_pkg::PosW'(P_MIN);
		if (r < 20) return ita_pkg::PosW'(P_MAX);
		if (r < 30) return ita_pkg::PosW'(int'($urandom_range(0, 64)) - 32);
		return ita_pkg::PosW'($urandom);
	endfunction

	function automatic logic [ita_pkg::MassW-1:0] pick_mass();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return ita_pkg::MassW'(M_MAX);
		return ita_pkg::MassW'($urandom);
	endfunction

	task automatic report(input string what, input logic [ita_pkg::SumW-1:0] got,
			input logic [ita_pkg::SumW-1:0] want);
		errors++;
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what,
			$signed(got), $signed(want));
	endtask

	task automatic check_tensor(input ita_pkg::res_beat_t got);
		ita_pkg::res_beat_t want;
		if (tensor_q.size() == 0) begin
			report("result beat with nothing pending", got.ixx, '0);
			return;
		end
		want = tensor_q.pop_front();
		tensors++;
		if (got.ixx !== want.ixx) report("ixx", got.ixx, want.ixx);
		if (got.iyy !== want.iyy) report("iyy", got.iyy, want.iyy);
		if (got.izz !== want.izz) report("izz", got.izz, want.izz);
		if (got.ixy !== want.ixy) report("ixy", got.ixy, want.ixy);
		if (got.ixz !== want.ixz) report("ixz", got.ixz, want.ixz);
		if (got.iyz !== want.iyz) report("iyz", got.iyz, want.iyz);
	endtask

	task automatic send_particle(input ita_pkg::pt_beat_t b, input bit typed,
			input ita_pkg::res_beat_t known);
		int                 gap;
		ita_pkg::res_beat_t t;
		gap = pick_gap();
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_valid <= 1'b1;
		pt <= b;
		do @(posedge clk); while (!pt_ready);
		particles++;
		if (absorb_particle(b, t)) tensor_q.push_back(typed ? known : t);
	endtask

	task automatic drain();
		pt_valid <= 1'b0;
		do @(posedge clk); while (tensor_q.size() != 0);
	endtask

	task automatic cfg_write(input logic [ita_pkg::CfgAddrW-1:0] a,
			input logic [ita_pkg::CfgDataW-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_data <= d;
		@(posedge clk);
		apply_reg(a, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_phase(input logic [ita_pkg::PosW-1:0] ox,
			input logic [ita_pkg::PosW-1:0] oy, input logic [ita_pkg::PosW-1:0] oz,
			input bit ie, input bit se, input logic [ita_pkg::CfgAddrW-1:0] spare);
		logic [ita_pkg::CfgDataW-1:0] d;
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_write(spare, ita_pkg::CfgDataW'($urandom));
		cfg_write(ita_pkg::CFG_ORIGIN_X, ox);
		cfg_write(ita_pkg::CFG_ORIGIN_Y, oy);
		cfg_write(ita_pkg::CFG_ORIGIN_Z, oz);
		d = ita_pkg::CfgDataW'($urandom);
		d[0] = ie;
		cfg_write(ita_pkg::CFG_USE_INSIDE, d);
		d = ita_pkg::CfgDataW'($urandom);
		d[0] = se;
		cfg_write(ita_pkg::CFG_USE_SHELL, d);
		cfg_write(spare, ita_pkg::CfgDataW'($urandom));
	endtask

	// long run of extreme particles drives sums onto the bounds, then a few pull them back
	task automatic saturate_set(input logic [ita_pkg::PosW-1:0] x,
			input logic [ita_pkg::PosW-1:0] y, input logic [ita_pkg::PosW-1:0] z,
			input logic [ita_pkg::PosW-1:0] x_back);
		for (int i = 0; i < SAT_RUN; i++)
			send_particle(mk_pt(x, y, z, ita_pkg::MassW'(M_MAX), 1, 1, 0), 0, '0);
		for (int i = 0; i < 3; i++)
			send_particle(mk_pt(x_back, y, z, ita_pkg::MassW'(M_MAX), 1, 1, 0), 0, '0);
		send_particle(mk_pt(x_back, y, z, 0, 1, 1, 1), 0, '0);
	endtask

	task automatic random_set();
		int                len, r;
		ita_pkg::pt_beat_t b;
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(1, 4);
		else if (r < 95) len = $urandom_range(5, 12);
		else len = $urandom_range(13, 40);
		for (int i = 0; i < len; i++) begin
			// a stray last now and then splits a set early
			b = mk_pt(pick_coord(), pick_coord(), pick_coord(), pick_mass(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				(i == len - 1) || ($urandom_range(0, 99) < 4));
			send_particle(b, 0, '0);
		end
	endtask

	initial begin
		int                  gap;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			check_tensor(res);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pt_valid && pt_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int                           start;
		logic [ita_pkg::PosW-1:0]     ox, oy, oz;
		logic [1:0]                   sets;
		logic [ita_pkg::CfgAddrW-1:0] spare;
		arst_n = 1'b0;
		pt_valid = 1'b0;
		pt = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		quiet = 1'b0;
		particles = 0;
		reset_model();
		load_rows();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < rows.size(); i++) begin
			if (i == both_from) begin
				drain();
				repeat (SETTLE) @(posedge clk);
				cfg_write(ita_pkg::CFG_USE_SHELL, ita_pkg::CfgDataW'(1));
			end
			send_particle(rows[i].b, rows[i].typed, rows[i].t);
		end

		configure_phase('0, '0, '0, 1'b1, 1'b1, CFG_SPARE_A);
		saturate_set(ita_pkg::PosW'(P_MIN), ita_pkg::PosW'(P_MIN), ita_pkg::PosW'(P_MIN),
			ita_pkg::PosW'(P_MAX));
		saturate_set(ita_pkg::PosW'(P_MAX), ita_pkg::PosW'(P_MIN), ita_pkg::PosW'(P_MAX),
			ita_pkg::PosW'(P_MIN));

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					ox = ita_pkg::PosW'(P_MIN);
					oy = ita_pkg::PosW'(P_MIN);
					oz = ita_pkg::PosW'(P_MIN);
				end
				1: begin
					ox = ita_pkg::PosW'(P_MAX);
					oy = ita_pkg::PosW'(P_MAX);
					oz = ita_pkg::PosW'(P_MAX);
				end
				2: begin
					ox = ita_pkg::PosW'(P_MAX);
					oy = ita_pkg::PosW'(P_MIN);
					oz = '0;
				end
				default: begin
					ox = pick_coord();
					oy = pick_coord();
					oz = pick_coord();
				end
			endcase
			sets = 2'(p + 1);
			if (p % 3 == 0) spare = CFG_SPARE_A;
			else if (p % 3 == 1) spare = CFG_SPARE_B;
			else spare = CFG_SPARE_C;
			configure_phase(ox, oy, oz, sets[1], sets[0], spare);
			quiet = (p % 3 == 2);
			start = particles;
			while (particles - start < PHASE_ITEMS) begin
				random_set();
				if ($urandom_range(0, 99) < 6) drain();
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("run covered %0d particles and %0d tensor results", particles, tensors);
		$display("across reset settings, %0d origin and set choices, and two saturation runs",
			N_PHASES + 1);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
